### rtl/tms_pkg.sv
package tms_pkg;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Occupancy of both runs, as seen by the pick unit
  typedef struct packed {
    cnt_t [1:0] counts;
    logic [1:0] ended;
  } run_state_t;

  // Decision of the pick unit
  typedef struct packed {
    logic valid;
    logic run;
  } pick_t;

  // One result word held in the output register
  typedef struct packed {
    value_t merged_value;
    logic   source_run;
    logic   merge_done;
    logic   push_error;
  } out_item_t;

endpackage

### rtl/tms_if.sv
interface tms_in_if;
  import tms_pkg::*;

  logic   valid;
  logic   ready;
  logic   run_id;
  value_t value;
  logic   run_last;

  modport source (output valid, output run_id, output value, output run_last, input ready);
  modport sink   (input valid, input run_id, input value, input run_last, output ready);
endinterface

interface tms_out_if;
  import tms_pkg::*;

  logic   valid;
  logic   ready;
  value_t merged_value;
  logic   source_run;
  logic   merge_done;
  logic   push_error;

  modport source (output valid, output merged_value, output source_run,
                  output merge_done, output push_error, input ready);
  modport sink   (input valid, input merged_value, input source_run,
                  input merge_done, input push_error, output ready);
endinterface

### rtl/two_way_merge_stream.sv
// Two-way merge of ascending runs.
//
// in_i carries one word per value: run_id (0 or 1), the 32-bit value and
// run_last on the final value of that run. out_o carries merged words:
// merged_value, source_run, merge_done on the final word of a merged pair of
// runs, and push_error on a word that reports a dropped push (run FIFO full,
// or run already ended).
//
// Each run has a FIFO of FIFO_DEPTH entries in a RAM with registered read.
// After a push is taken, a small sequencer reads both heads, lets one shared
// comparator pick the smaller (ties to run 0), and loads the output register.
// Per merged word the sequencer steps through a RAM read state, then a compare
// state that loads the output register; a push that emits nothing also passes
// both states with in_i.ready low before the next push can be taken. An
// error word appears in the next cycle. in_i.ready is high only while the
// sequencer is idle and the output register is empty.
//
// When out_o.ready is low the output word holds and the sequencer waits.
// Reset clears counts, heads and end flags; RAM contents need no clearing.
// After the merge_done word the block is back to its reset state.
module two_way_merge_stream (
  input  logic   clk_i,
  input  logic   rst_ni,
  tms_in_if.sink    in_i,
  tms_out_if.source out_o
);
  import tms_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state_q, state_d;
  cnt_t [1:0] counts_q, counts_d;
  ptr_t [1:0] heads_q, heads_d;
  logic [1:0] ended_q, ended_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic       in_take;
  logic       push_bad;
  logic [1:0] we;
  logic [CNT_W:0] wsum;
  ptr_t       waddr;
  value_t     head0, head1;
  run_state_t run_state;
  pick_t      pick;
  logic       out_free;
  logic       done;
  ptr_t       head_next;

  // Heads are always on the RAM read ports; data follows in the next cycle
  tms_ram #(.WIDTH(VALUE_W), .DEPTH(FIFO_DEPTH)) u_ram0 (
    .clk_i  (clk_i),
    .we_i   (we[0]),
    .waddr_i(waddr),
    .wdata_i(in_i.value),
    .raddr_i(heads_q[0]),
    .rdata_o(head0)
  );

  tms_ram #(.WIDTH(VALUE_W), .DEPTH(FIFO_DEPTH)) u_ram1 (
    .clk_i  (clk_i),
    .we_i   (we[1]),
    .waddr_i(waddr),
    .wdata_i(in_i.value),
    .raddr_i(heads_q[1]),
    .rdata_o(head1)
  );

  assign run_state.counts = counts_q;
  assign run_state.ended  = ended_q;

  tms_pick u_pick (
    .state_i(run_state),
    .head0_i(head0),
    .head1_i(head1),
    .pick_o (pick)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && !out_valid_q;
  assign in_take     = in_i.valid && in_i.ready;
  assign push_bad    = ended_q[in_i.run_id] ||
                       (counts_q[in_i.run_id] == cnt_t'(FIFO_DEPTH));

  // Tail slot: head plus count, wrapped once
  always_comb begin
    wsum = (CNT_W+1)'(heads_q[in_i.run_id]) + (CNT_W+1)'(counts_q[in_i.run_id]);
    if (wsum >= (CNT_W+1)'(FIFO_DEPTH)) begin
      wsum = wsum - (CNT_W+1)'(FIFO_DEPTH);
    end
    waddr = wsum[PTR_W-1:0];
  end

  always_comb begin
    we = '0;
    if (in_take && !push_bad) begin
      we[in_i.run_id] = 1'b1;
    end
  end

  assign head_next = (heads_q[pick.run] == ptr_t'(FIFO_DEPTH - 1)) ? '0
                   : heads_q[pick.run] + 1'b1;

  // Last word: both runs ended and the pop empties the final entry
  assign done = ended_q[0] && ended_q[1] &&
                (counts_q[pick.run] == cnt_t'(1)) &&
                (counts_q[!pick.run] == '0);

  always_comb begin
    state_d     = state_q;
    counts_d    = counts_q;
    heads_d     = heads_q;
    ended_d     = ended_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (push_bad) begin
            // Drop the push and report it
            out_valid_d       = 1'b1;
            out_d.merged_value = '0;
            out_d.source_run   = in_i.run_id;
            out_d.merge_done   = 1'b0;
            out_d.push_error   = 1'b1;
          end else begin
            counts_d[in_i.run_id] = counts_q[in_i.run_id] + 1'b1;
            if (in_i.run_last) begin
              ended_d[in_i.run_id] = 1'b1;
            end
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!pick.valid) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.merged_value = pick.run ? head1 : head0;
          out_d.source_run   = pick.run;
          out_d.merge_done   = done;
          out_d.push_error   = 1'b0;
          if (done) begin
            // Clear for the next pair of runs
            counts_d = '0;
            heads_d  = '0;
            ended_d  = '0;
            state_d  = S_IDLE;
          end else begin
            counts_d[pick.run] = counts_q[pick.run] - 1'b1;
            heads_d[pick.run]  = head_next;
            state_d            = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      counts_q    <= '0;
      heads_q     <= '0;
      ended_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      counts_q    <= counts_d;
      heads_q     <= heads_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_q.merged_value;
  assign out_o.source_run   = out_q.source_run;
  assign out_o.merge_done   = out_q.merge_done;
  assign out_o.push_error   = out_q.push_error;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (counts_q[0] <= cnt_t'(FIFO_DEPTH)) && (counts_q[1] <= cnt_t'(FIFO_DEPTH)))
    else $error("run FIFO count exceeds depth");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && push_bad) |=> (out_valid_q && out_q.push_error && (state_q == S_IDLE)))
    else $error("dropped push not reported");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && pick.valid && out_free && done) |=>
      (counts_q == '0 && ended_q == '0 && state_q == S_IDLE))
    else $error("state not cleared after final word");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && pick.valid) |-> (counts_q[pick.run] != '0))
    else $error("pop from empty run FIFO");
`endif

endmodule

### rtl/tms_ram.sv
module tms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tms_pick.sv
module tms_pick (
  input  tms_pkg::run_state_t state_i,
  input  tms_pkg::value_t     head0_i,
  input  tms_pkg::value_t     head1_i,
  output tms_pkg::pick_t      pick_o
);
  import tms_pkg::*;

  logic has0;
  logic has1;

  assign has0 = (state_i.counts[0] != '0);
  assign has1 = (state_i.counts[1] != '0);

  // Smaller head wins while both runs hold data; ties go to run 0
  always_comb begin
    pick_o = '0;
    if (has0 && has1) begin
      pick_o.valid = 1'b1;
      pick_o.run   = !(head0_i <= head1_i);
    end else if (has0 && state_i.ended[1]) begin
      pick_o.valid = 1'b1;
      pick_o.run   = 1'b0;
    end else if (has1 && state_i.ended[0]) begin
      pick_o.valid = 1'b1;
      pick_o.run   = 1'b1;
    end
  end

endmodule
